// ===== rtl/bmh_pkg.sv =====
// ----------------------------------------------------------------------------
// bmh_pkg
// shared types and codes for the binary min-heap priority queue
// ----------------------------------------------------------------------------
package bmh_pkg;

  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 10;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 1023;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic [COUNT_W-1:0]      entry_count;
    logic [STATUS_W-1:0]     status;
  } out_word_t;

endpackage

// ===== rtl/bmh_store.sv =====
// ----------------------------------------------------------------------------
// bmh_store
// key store: one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module bmh_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== rtl/binary_min_heap.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap
// min-heap priority queue of signed keys, one-based store, sift by a sequencer
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid_i/in_stall_o | command, value
//  out     | output    | out_valid_o/out_stall_i | removed_key, count, status
//
//  insert climbs from the new last slot toward the root; remove moves the last
//  key to the root and descends toward the leaves; refused words go straight
//  to the result. the sift is paced by the registered store reads and the one
//  comparator shared by every step of the sift.
//  reset empties the queue at once; the store needs no clearing pass.
//  a result waiting on out_stall_i does not hold off the next word; only a
//  second finished result waits for the output register.
//
module binary_min_heap #(
  parameter int CAPACITY = bmh_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmh_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmh_pkg::out_word_t  out_word_o
);

  import bmh_pkg::*;

  localparam int DEPTH = CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_REM_WAIT,
    ST_DN_RD,
    ST_DN_PICK,
    ST_DN_CMP,
    ST_FIN
  } state_e;

  state_e                  state_q, state_d;
  logic [AW-1:0]           count_q, count_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [AW-1:0]           pick_q, pick_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [KEY_W-1:0] child_q, child_d;
  logic signed [KEY_W-1:0] removed_q, removed_d;
  logic [STATUS_W-1:0]     stat_q, stat_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [KEY_W-1:0]        mem_wdata, rd_a, rd_b;

  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_lt;

  logic [AW:0]             left, right;
  logic                    left_ok, right_ok;
  logic [31:0]             count_ext;
  logic                    accept;

  bmh_store #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (KEY_W)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(mem_raddr_a),
    .raddr_b_i(mem_raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign left     = {pos_q, 1'b0};
  assign right    = left + {{AW{1'b0}}, 1'b1};
  assign left_ok  = (left <= {1'b0, count_q});
  assign right_ok = (right <= {1'b0, count_q});
  assign count_ext = 32'(count_q);

  // the one comparator, operands picked by the sequencer
  always_comb begin
    cmp_a = key_q;
    cmp_b = $signed(rd_a);
    case (state_q)
      ST_DN_PICK: begin
        cmp_a = $signed(rd_b);
        cmp_b = $signed(rd_a);
      end
      ST_DN_CMP: begin
        cmp_a = child_q;
        cmp_b = key_q;
      end
      default: begin
        cmp_a = key_q;
        cmp_b = $signed(rd_a);
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    pick_d      = pick_q;
    key_d       = key_q;
    child_d     = child_q;
    removed_d   = removed_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = key_q;
    mem_raddr_a = pos_q >> 1;
    mem_raddr_b = count_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        // root and last slot are read ahead for a remove
        mem_raddr_a = {{(AW-1){1'b0}}, 1'b1};
        mem_raddr_b = count_q;
        if (accept) begin
          removed_d = '0;
          stat_d    = STAT_OK;
          if (in_word_i.command == CMD_INSERT) begin
            if (count_q >= AW'(CAPACITY)) begin
              stat_d  = STAT_FULL;
              state_d = ST_FIN;
            end else begin
              count_d = count_q + 1'b1;
              pos_d   = count_q + 1'b1;
              key_d   = in_word_i.value;
              state_d = ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = STAT_EMPTY;
              state_d = ST_FIN;
            end else begin
              count_d = count_q - 1'b1;
              state_d = ST_REM_WAIT;
            end
          end
        end
      end
      ST_UP_RD: begin
        mem_raddr_a = pos_q >> 1;
        if (pos_q == {{(AW-1){1'b0}}, 1'b1}) begin
          mem_we  = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          // parent larger: it drops into the hole
          mem_wdata = rd_a;
          pos_d     = pos_q >> 1;
          state_d   = ST_UP_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_REM_WAIT: begin
        removed_d = $signed(rd_a);
        key_d     = $signed(rd_b);
        pos_d     = {{(AW-1){1'b0}}, 1'b1};
        state_d   = ST_DN_RD;
      end
      ST_DN_RD: begin
        mem_raddr_a = left[AW-1:0];
        mem_raddr_b = right_ok ? right[AW-1:0] : left[AW-1:0];
        if (!left_ok) begin
          mem_we  = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_DN_PICK;
        end
      end
      ST_DN_PICK: begin
        // left child wins a tie
        if (right_ok && cmp_lt) begin
          child_d = $signed(rd_b);
          pick_d  = right[AW-1:0];
        end else begin
          child_d = $signed(rd_a);
          pick_d  = left[AW-1:0];
        end
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = child_q;
          pos_d     = pick_q;
          state_d   = ST_DN_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_word_d.removed_key = removed_q;
          out_word_d.entry_count = count_ext[COUNT_W-1:0];
          out_word_d.status      = stat_q;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      pick_q      <= '0;
      key_q       <= '0;
      child_q     <= '0;
      removed_q   <= '0;
      stat_q      <= STAT_OK;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      pick_q      <= pick_d;
      key_q       <= key_d;
      child_q     <= child_d;
      removed_q   <= removed_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

endmodule

// ===== bench/binary_min_heap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_checker
// watches both channels of the min-heap, keeps its own heap and count, and
// compares every result word field by field with the oldest predicted word
// ----------------------------------------------------------------------------
module binary_min_heap_checker #(
  parameter int CAPACITY = bmh_pkg::DEF_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  bmh_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  bmh_pkg::out_word_t out_word_i,
  output int                 err_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 full_refusals_o,
  output int                 empty_refusals_o,
  output int                 peak_keys_o
);

  import bmh_pkg::*;

  logic signed [KEY_W-1:0] heap_keys [1:CAPACITY];
  int unsigned             key_total = 0;
  out_word_t               exp_results [$];

  int n_err       = 0;
  int n_pending   = 0;
  int n_results   = 0;
  int n_full      = 0;
  int n_empty     = 0;
  int n_peak      = 0;

  assign err_count_o      = n_err;
  assign pending_o        = n_pending;
  assign results_o        = n_results;
  assign full_refusals_o  = n_full;
  assign empty_refusals_o = n_empty;
  assign peak_keys_o      = n_peak;

  // applies one word to the local heap and returns the result it should give
  function automatic out_word_t apply_heap_op(in_word_t w);
    out_word_t               r;
    logic signed [KEY_W-1:0] t;
    int unsigned             p;
    int unsigned             c;
    r = '0;
    if (w.command == CMD_INSERT) begin
      if (key_total >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        key_total++;
        heap_keys[key_total] = w.value;
        p = key_total;
        // climb while the parent is strictly larger, never past the root
        while (p > 1 && heap_keys[p / 2] > heap_keys[p]) begin
          t                = heap_keys[p];
          heap_keys[p]     = heap_keys[p / 2];
          heap_keys[p / 2] = t;
          p                = p / 2;
        end
      end
    end else begin
      if (key_total == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.removed_key = heap_keys[1];
        heap_keys[1]  = heap_keys[key_total];
        key_total--;
        p = 1;
        while (2 * p <= key_total) begin
          c = 2 * p;
          // right child only if present and strictly smaller, left wins ties
          if (c + 1 <= key_total && heap_keys[c + 1] < heap_keys[c]) c = c + 1;
          if (heap_keys[c] < heap_keys[p]) begin
            t            = heap_keys[p];
            heap_keys[p] = heap_keys[c];
            heap_keys[c] = t;
            p            = c;
          end else begin
            break;
          end
        end
      end
    end
    r.entry_count = COUNT_W'(key_total);
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t got;
    if (rst_ni) begin
      // a result accepted now always belongs to a word accepted earlier
      if (out_valid_i && !out_stall_i) begin
        n_results++;
        got = out_word_i;
        if (exp_results.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result word: expected none, got key %0d count %0d status %0d",
                   $time, got.removed_key, got.entry_count, got.status);
        end else begin
          want = exp_results.pop_front();
          if (got.removed_key !== want.removed_key) begin
            n_err++;
            $display("%0t: removed_key mismatch: expected %0d, got %0d",
                     $time, want.removed_key, got.removed_key);
          end
          if (got.entry_count !== want.entry_count) begin
            n_err++;
            $display("%0t: entry_count mismatch: expected %0d, got %0d",
                     $time, want.entry_count, got.entry_count);
          end
          if (got.status !== want.status) begin
            n_err++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, got.status);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_heap_op(in_word_i);
        exp_results.push_back(want);
        if (want.status == STAT_FULL) n_full++;
        if (want.status == STAT_EMPTY) n_empty++;
        if (int'(key_total) > n_peak) n_peak = key_total;
      end
      n_pending = exp_results.size();
    end
  end

endmodule

// ===== bench/binary_min_heap_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_tb
// drives insert and remove words into the min-heap in random bursts while the
// result side stalls on its own pattern; the checker predicts and compares
// ----------------------------------------------------------------------------
module binary_min_heap_tb;
  import bmh_pkg::*;

  localparam int CAP         = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 60;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = ~KEY_MIN;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_STICKY} stall_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int err_count;
  int pending;
  int results;
  int full_refusals;
  int empty_refusals;
  int peak_keys;

  int cycle_count = 0;
  int burst_left  = 0;
  int level       = 0;

  binary_min_heap #(
    .CAPACITY (CAP)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  binary_min_heap_checker #(
    .CAPACITY (CAP)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_word_i       (out_word),
    .err_count_o      (err_count),
    .pending_o        (pending),
    .results_o        (results),
    .full_refusals_o  (full_refusals),
    .empty_refusals_o (empty_refusals),
    .peak_keys_o      (peak_keys)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // a quarter small keys near zero for ties, an eighth extremes, the rest full-width random keys
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 7))
      0, 1:    k = KEY_W'($urandom_range(0, 8)) - KEY_W'(4);
      2:       k = ($urandom_range(0, 1) == 1) ? KEY_MAX : KEY_MIN;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // one word through the input channel, with a random gap between bursts
  task automatic push_word(input logic cmd, input logic signed [KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= '{command: cmd, value: key};
    do @(posedge clk_i); while (in_stall);
    if (cmd == CMD_INSERT && level < CAP) level++;
    if (cmd == CMD_REMOVE && level > 0) level--;
  endtask

  // receiver stall pattern, switching between modes at random
  initial begin
    stall_mode_e mode;
    int          span;
    @(posedge rst_ni);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
        endcase
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // removes on an empty heap
    push_word(CMD_REMOVE, KEY_MAX);
    push_word(CMD_REMOVE, '0);
    // extremes, climbs to the root, equal keys
    push_word(CMD_INSERT, '0);
    push_word(CMD_INSERT, KEY_MAX);
    push_word(CMD_INSERT, KEY_MIN);
    push_word(CMD_INSERT, -1);
    push_word(CMD_INSERT, 1);
    push_word(CMD_INSERT, 5);
    push_word(CMD_INSERT, 5);
    push_word(CMD_INSERT, 5);
    push_word(CMD_INSERT, 7);
    push_word(CMD_INSERT, -1);
    // drain past empty: ties between children, lone left child
    repeat (11) push_word(CMD_REMOVE, $urandom);

    // shallow mixed traffic, hits the empty case now and then
    repeat (250) begin
      push_word(($urandom_range(0, 1) == 1) ? CMD_REMOVE : CMD_INSERT, pick_key());
    end
    // fill to capacity with a few removes mixed in
    while (level < CAP) begin
      push_word(($urandom_range(0, 31) == 0) ? CMD_REMOVE : CMD_INSERT, pick_key());
    end
    repeat (6) push_word(CMD_INSERT, pick_key());
    push_word(CMD_REMOVE, pick_key());
    repeat (3) push_word(CMD_INSERT, pick_key());
    // deep removes from a nearly full heap
    repeat (550) begin
      push_word(($urandom_range(0, 3) != 0) ? CMD_REMOVE : CMD_INSERT, pick_key());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d words, heap depth up to %0d keys, with bursty input and random stalls",
             results, peak_keys);
    $display("refused inserts on a full heap: %0d, refused removes on an empty heap: %0d",
             full_refusals, empty_refusals);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
